// ===== rtl/svt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svt_pkg
// Shared types and constants for the sorted value table.
// ----------------------------------------------------------------------------
package svt_pkg;

  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int FIELD_W  = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CMP,
    FSM_SHIFT,
    FSM_DONE
  } fsm_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

// ===== rtl/svt_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svt_ifs
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface svt_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic signed [svt_pkg::FIELD_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface svt_out_if;
  logic                                valid;
  logic                                ready;
  logic        [svt_pkg::STATUS_W-1:0] status;
  logic        [svt_pkg::POS_W-1:0]    position;
  logic        [svt_pkg::COUNT_W-1:0]  count;
  logic signed [svt_pkg::FIELD_W-1:0]  smallest;
  logic signed [svt_pkg::FIELD_W-1:0]  largest;

  modport source (output valid, output status, output position, output count,
                  output smallest, output largest, input ready);
  modport sink   (input valid, input status, input position, input count,
                  input smallest, input largest, output ready);
endinterface

// ===== rtl/svt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svt_cell
// One slot of the sorted row: holds a value, compares it against the
// command value and shifts with its neighbors on insert or delete.
// ----------------------------------------------------------------------------
module svt_cell #(
  parameter int IDX         = 0,
  parameter int VALUE_WIDTH = 32,
  parameter int CW          = 5
) (
  input  logic                          clk,
  input  svt_pkg::cell_cmd_t            cmd,
  input  logic signed [VALUE_WIDTH-1:0] cmd_value,
  input  logic        [CW-1:0]          count,
  input  logic signed [VALUE_WIDTH-1:0] left_val,
  input  logic                          left_ge,
  input  logic signed [VALUE_WIDTH-1:0] right_val,
  output logic signed [VALUE_WIDTH-1:0] val,
  output logic                          ge,
  output logic                          eq
);

  logic signed [VALUE_WIDTH-1:0] val_r;
  logic                          ge_r;
  logic                          eq_r;
  logic                          occupied;

  assign occupied = count > CW'(IDX);

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      // empty slots count as above every value
      ge_r <= !occupied || (val_r >= cmd_value);
      eq_r <= occupied && (val_r == cmd_value);
    end
    if (cmd.ins) begin
      if (ge_r && !left_ge) begin
        val_r <= cmd_value;
      end else if (left_ge) begin
        val_r <= left_val;
      end
    end else if (cmd.del && ge_r) begin
      val_r <= right_val;
    end
  end

  assign val = val_r;
  assign ge  = ge_r;
  assign eq  = eq_r;

endmodule

// ===== rtl/sorted_value_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_value_table
// Ordered table of signed values with insert and delete commands.
// ----------------------------------------------------------------------------
// Values live in a row of DEPTH cells in ascending order. Each item goes
// through accept, a compare in every cell against the command value, a
// shift of the row toward or away from the affected slot, and the result
// capture, which waits while an earlier result is still untaken. The result
// sits in an output register, so the next item is accepted while a result
// still waits to be taken. A new item is accepted only after the result of
// the last one has been captured.
// ----------------------------------------------------------------------------
module sorted_value_table #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  svt_in_if.sink    in_chan,
  svt_out_if.source out_chan
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  svt_pkg::fsm_t    state_r, state_nxt;
  svt_pkg::op_t     op_r;
  svt_pkg::status_t status_r;
  svt_pkg::cell_cmd_t cmd;

  logic signed [VALUE_WIDTH-1:0] value_r;
  logic        [CW-1:0]          count_r, count_nxt;
  logic        [IW-1:0]          pos_r;

  logic signed [VALUE_WIDTH-1:0] cell_val [DEPTH];
  logic        [DEPTH-1:0]       cell_ge;
  logic        [DEPTH-1:0]       cell_eq;
  logic        [DEPTH-1:0]       first;
  logic        [IW-1:0]          first_pos;
  logic                          found;
  logic                          full;
  logic signed [VALUE_WIDTH-1:0] largest_sel;
  logic                          out_load;

  logic                               out_valid_r;
  svt_pkg::status_t                   out_status_r;
  logic        [svt_pkg::POS_W-1:0]   out_position_r;
  logic        [svt_pkg::COUNT_W-1:0] out_count_r;
  logic signed [svt_pkg::FIELD_W-1:0] out_smallest_r;
  logic signed [svt_pkg::FIELD_W-1:0] out_largest_r;

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] left_val;
    logic signed [VALUE_WIDTH-1:0] right_val;
    logic                          left_ge;

    if (i == 0) begin : g_head
      assign left_val = cell_val[i];
      assign left_ge  = 1'b0;
    end else begin : g_body
      assign left_val = cell_val[i-1];
      assign left_ge  = cell_ge[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_val = cell_val[i];
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end

    svt_cell #(
      .IDX         (i),
      .VALUE_WIDTH (VALUE_WIDTH),
      .CW          (CW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .cmd_value (value_r),
      .count     (count_r),
      .left_val  (left_val),
      .left_ge   (left_ge),
      .right_val (right_val),
      .val       (cell_val[i]),
      .ge        (cell_ge[i]),
      .eq        (cell_eq[i])
    );
  end

  // boundary of the row and slot encode
  always_comb begin
    first_pos   = '0;
    largest_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      first[i]  = cell_ge[i] && ((i == 0) ? 1'b1 : !cell_ge[(i == 0) ? 0 : i - 1]);
      first_pos = first_pos | (first[i] ? IW'(i) : '0);
      largest_sel = largest_sel |
                    ((count_r == CW'(i + 1)) ? cell_val[i] : '0);
    end
  end

  assign found = |(first & cell_eq);
  assign full  = count_r == CW'(DEPTH);

  always_comb begin
    cmd.cmp = state_r == svt_pkg::FSM_CMP;
    cmd.ins = (state_r == svt_pkg::FSM_SHIFT) && (op_r == svt_pkg::OP_INSERT) && !full;
    cmd.del = (state_r == svt_pkg::FSM_SHIFT) && (op_r == svt_pkg::OP_DELETE) && found;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      svt_pkg::FSM_IDLE: begin
        if (in_chan.valid) state_nxt = svt_pkg::FSM_CMP;
      end
      svt_pkg::FSM_CMP: begin
        state_nxt = svt_pkg::FSM_SHIFT;
      end
      svt_pkg::FSM_SHIFT: begin
        state_nxt = svt_pkg::FSM_DONE;
      end
      svt_pkg::FSM_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = svt_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = svt_pkg::FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.del) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= svt_pkg::FSM_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      op_r    <= svt_pkg::op_t'(in_chan.opcode);
      value_r <= VALUE_WIDTH'(in_chan.value);
    end
    if (state_r == svt_pkg::FSM_SHIFT) begin
      if (op_r == svt_pkg::OP_INSERT) begin
        status_r <= full ? svt_pkg::ST_FULL : svt_pkg::ST_INSERTED;
        pos_r    <= full ? '0 : first_pos;
      end else begin
        status_r <= found ? svt_pkg::ST_DELETED : svt_pkg::ST_NOT_FOUND;
        pos_r    <= found ? first_pos : '0;
      end
    end
    if (out_load) begin
      out_status_r   <= status_r;
      out_position_r <= svt_pkg::POS_W'(pos_r);
      out_count_r    <= svt_pkg::COUNT_W'(count_r);
      out_smallest_r <= (count_r != '0) ? svt_pkg::FIELD_W'(cell_val[0]) : '0;
      out_largest_r  <= svt_pkg::FIELD_W'(largest_sel);
    end
  end

  assign in_chan.ready     = state_r == svt_pkg::FSM_IDLE;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.status   = out_status_r;
  assign out_chan.position = out_position_r;
  assign out_chan.count    = out_count_r;
  assign out_chan.smallest = out_smallest_r;
  assign out_chan.largest  = out_largest_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_one_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == svt_pkg::FSM_SHIFT |-> $onehot0(first))
    else $error("more than one insert boundary in the row");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the count by one");

  a_miss_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == svt_pkg::FSM_SHIFT && op_r == svt_pkg::OP_DELETE && !found)
      |=> $stable(count_r))
    else $error("delete miss changed the count");

endmodule
